/* hdl/dual_ended_stack_assert.svh */
// Assertion macros for the dual-ended stack modules, used by the controller.
`ifndef DUAL_ENDED_STACK_ASSERT_SVH
`define DUAL_ENDED_STACK_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define DES_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dual_ended_stack: check failed");

// Next-cycle implication, sampled on aclk, off while in reset
`define DES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dual_ended_stack: check failed");

`endif

/* hdl/des_pkg.sv */
// Shared types and constants of the dual-ended stack.
`default_nettype none

package des_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 7;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;
    localparam int ADDR_W    = 3;
    localparam int PDATA_W   = 32;
    localparam int DEPTH_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_L = 3'd0,
        FN_PUSH_R = 3'd1,
        FN_POP_L  = 3'd2,
        FN_POP_R  = 3'd3,
        FN_PEEK_L = 3'd4,
        FN_PEEK_R = 3'd5
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } state_t;

    typedef struct packed {
        logic exec;      // perform the accepted item's operation
        logic load_out;  // capture the result into the output registers
    } ctrl_cmd_t;

endpackage

`default_nettype wire

/* hdl/des_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none

module des_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on we, read old contents every enabled cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/des_ctrl.sv */
// Handshake controller of the dual-ended stack.
`default_nettype none

`include "dual_ended_stack_assert.svh"

module des_ctrl
    import des_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state, clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance: accept, wait for the RAM read, then present the result
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = s_valid ? S_READ : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Drive handshakes and datapath commands
    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_READ: begin
                cmd.load_out = 1'b1;
            end
            S_RESP: begin
                m_valid = 1'b1;
                s_ready = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.exec = s_valid && s_ready;
    end

    `DES_ASSERT_NEXT(a_exec_then_load, cmd.exec, cmd.load_out)
    `DES_ASSERT_NEXT(a_load_then_valid, cmd.load_out, m_valid)
    `DES_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready && !m_valid)

endmodule

`default_nettype wire

/* hdl/des_dp.sv */
// Datapath of the dual-ended stack: counts, capacity register, store, result.
`default_nettype none

module des_dp
    import des_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ctrl_cmd_t          cmd,
    input  wire logic [FUNC_W-1:0]  s_func,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic signed [DATA_W-1:0] m_data,
    output logic [STAT_W-1:0]       m_status,
    output logic                    m_left_empty,
    output logic                    m_right_empty,
    output logic                    m_store_full,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = (AW > CAP_W) ? AW : CAP_W;
    localparam int DW = $clog2(DEPTH + 1);
    localparam int CW = (DW > CAP_W) ? DW : CAP_W;

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] left_cnt_reg, left_cnt_next;
    logic [CAP_W-1:0] right_cnt_reg, right_cnt_next;
    stat_t            pstat_reg, pstat_next;
    logic             prd_reg, prd_next;

    logic signed [DATA_W-1:0] data_reg;
    stat_t                    status_reg;
    logic                     lempty_reg;
    logic                     rempty_reg;
    logic                     full_reg;

    logic              cfg_wr;
    logic [CW-1:0]     cap_ext;
    logic [CW-1:0]     cap_lim;
    logic [CAP_W-1:0]  cap_eff;
    logic [CAP_W:0]    cnt_sum;
    logic [CAP_W:0]    cnt_sum_next;
    logic              full_now;
    logic [CAP_W-1:0]  idx;
    logic [IW-1:0]     idx_ext;
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_q;

    // Register port: one capacity register, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    // Saturate the capacity to the store depth
    assign cap_ext = CW'(cap_reg);
    assign cap_lim = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
    assign cap_eff = cap_lim[CAP_W-1:0];

    assign cnt_sum  = {1'b0, left_cnt_reg} + {1'b0, right_cnt_reg};
    assign full_now = cnt_sum >= {1'b0, cap_eff};

    // Decode the operation: new counts, store access, status
    always_comb begin
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        pstat_next     = ST_OK;
        prd_next       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        idx            = left_cnt_reg;
        case (func_t'(s_func))
            FN_PUSH_L: begin
                if (full_now) begin
                    pstat_next = ST_OVERFLOW;
                end else begin
                    ram_we        = 1'b1;
                    idx           = left_cnt_reg;
                    left_cnt_next = left_cnt_reg + 1'b1;
                end
            end
            FN_PUSH_R: begin
                if (full_now) begin
                    pstat_next = ST_OVERFLOW;
                end else begin
                    ram_we         = 1'b1;
                    idx            = cap_eff - right_cnt_reg - 1'b1;
                    right_cnt_next = right_cnt_reg + 1'b1;
                end
            end
            FN_POP_L, FN_PEEK_L: begin
                if (left_cnt_reg == '0) begin
                    pstat_next = ST_UNDERFLOW;
                end else begin
                    ram_re   = 1'b1;
                    prd_next = 1'b1;
                    idx      = left_cnt_reg - 1'b1;
                    if (func_t'(s_func) == FN_POP_L) begin
                        left_cnt_next = left_cnt_reg - 1'b1;
                    end
                end
            end
            FN_POP_R, FN_PEEK_R: begin
                if (right_cnt_reg == '0) begin
                    pstat_next = ST_UNDERFLOW;
                end else begin
                    ram_re   = 1'b1;
                    prd_next = 1'b1;
                    idx      = cap_eff - right_cnt_reg;
                    if (func_t'(s_func) == FN_POP_R) begin
                        right_cnt_next = right_cnt_reg - 1'b1;
                    end
                end
            end
            default: begin
                pstat_next = ST_OK;
            end
        endcase
    end

    assign idx_ext = IW'(idx);

    // Word store
    des_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (cmd.exec && (ram_we || ram_re)),
        .we    (ram_we),
        .addr  (idx_ext[AW-1:0]),
        .wdata (s_value),
        .rdata (ram_q)
    );

    // Hold capacity and counts; a capacity write empties both stacks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
        end else if (cfg_wr) begin
            cap_reg       <= pwdata[CAP_W-1:0];
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
        end else if (cmd.exec) begin
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
        end
    end

    // Hold the decode results until the read data returns
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            pstat_reg <= pstat_next;
            prd_reg   <= prd_next;
        end
    end

    assign cnt_sum_next = {1'b0, left_cnt_reg} + {1'b0, right_cnt_reg};

    // Capture the result item
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            data_reg   <= prd_reg ? ram_q : '0;
            status_reg <= pstat_reg;
            lempty_reg <= (left_cnt_reg == '0);
            rempty_reg <= (right_cnt_reg == '0);
            full_reg   <= cnt_sum_next >= {1'b0, cap_eff};
        end
    end

    assign m_data        = data_reg;
    assign m_status      = status_reg;
    assign m_left_empty  = lempty_reg;
    assign m_right_empty = rempty_reg;
    assign m_store_full  = full_reg;

endmodule

`default_nettype wire

/* hdl/dual_ended_stack.sv */
// A result item is valid once its input item is accepted, the word store read
// is captured into the output registers in S_READ and S_RESP presents it.
// A new item is accepted only in S_IDLE, or in S_RESP as m_ready takes the result.
// Reset (aresetn low, synchronous): both stacks empty, capacity 64.
// The word store is not cleared; no clearing pass follows reset.
`default_nettype none

module dual_ended_stack
    import des_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [FUNC_W-1:0]        s_func,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_data,
    output logic [STAT_W-1:0]             m_status,
    output logic                          m_left_empty,
    output logic                          m_right_empty,
    output logic                          m_store_full,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready
);

    ctrl_cmd_t cmd;

    // Sequence items through the handshakes
    des_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Stack pointers, store and result registers
    des_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_func        (s_func),
        .s_value       (s_value),
        .m_data        (m_data),
        .m_status      (m_status),
        .m_left_empty  (m_left_empty),
        .m_right_empty (m_right_empty),
        .m_store_full  (m_store_full),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

endmodule

`default_nettype wire
